@@ design/ecr_pkg.sv @@
package ecr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CW = 36;                 // cordic x/y datapath width
    localparam int AW = 33;                 // cordic angle width
    localparam int NW = 28;                 // normal/tangent component width
    localparam int QB = 28;                 // quotient bits
    localparam int DENW = 17;
    localparam int NUMW = 47;
    localparam int QW = QB + 1;
    localparam int LV = CORDIC_STAGES + 1;  // cordic latency
    localparam int LD = QB + 2;             // divider latency
    localparam int NV = LV * 3 + LD + 8;    // total latency

    localparam logic [29:0] KINV = 30'd652032874;

    localparam logic [31:0] ATAN_TAB [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [15:0] pos_a_x;
        logic signed [15:0] pos_a_y;
        logic signed [15:0] pos_b_x;
        logic signed [15:0] pos_b_y;
        logic [15:0]        speed_a;
        logic [15:0]        heading_a;
        logic [15:0]        mass_a;
        logic [15:0]        speed_b;
        logic [15:0]        heading_b;
        logic [15:0]        mass_b;
    } t_in_word;

    typedef struct packed {
        logic [15:0] new_speed_a;
        logic [15:0] new_heading_a;
        logic [15:0] new_speed_b;
        logic [15:0] new_heading_b;
    } t_out_word;

    typedef struct packed {
        logic        nz;
        logic [23:0] x0a;
        logic [23:0] x0b;
        logic [15:0] ha;
        logic [15:0] hb;
        logic [15:0] ma;
        logic [15:0] mb;
    } t_sb_vec;

    typedef struct packed {
        logic [31:0] phi;
        logic [15:0] ma;
        logic [15:0] mb;
    } t_sb_rot;

    typedef struct packed {
        logic [31:0]          phi;
        logic signed [NW-1:0] nay;
        logic signed [NW-1:0] nby;
    } t_sb_div;

    typedef struct packed {
        logic [31:0] phi;
        logic        za;
        logic        zb;
    } t_sb_out;

endpackage

@@ design/ecr_cordic.sv @@
module ecr_cordic (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_vec,
    input  logic signed [ecr_pkg::CW-1:0] i_x,
    input  logic signed [ecr_pkg::CW-1:0] i_y,
    input  logic signed [ecr_pkg::AW-1:0] i_z,
    output logic signed [ecr_pkg::CW-1:0] o_x,
    output logic signed [ecr_pkg::CW-1:0] o_y,
    output logic signed [ecr_pkg::AW-1:0] o_z
);
    import ecr_pkg::*;

    localparam logic signed [AW-1:0] QTR  = 33'sh040000000;
    localparam logic signed [AW-1:0] HALF = 33'sh080000000;

    logic signed [CW-1:0] r_x [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_y [CORDIC_STAGES+1];
    logic signed [AW-1:0] r_z [CORDIC_STAGES+1];
    logic signed [CW-1:0] n_x [CORDIC_STAGES];
    logic signed [CW-1:0] n_y [CORDIC_STAGES];
    logic signed [AW-1:0] n_z [CORDIC_STAGES];
    logic signed [CW-1:0] n_x0, n_y0;
    logic signed [AW-1:0] n_z0, t;

    // fold into the right half plane
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        t    = AW'(signed'(i_z[31:0]));
        n_z0 = t;
        if (i_vec) begin
            n_z0 = '0;
            if (i_x < 0) begin
                n_x0 = -i_x;
                n_y0 = -i_y;
                n_z0 = HALF;
            end
        end else if (t > QTR) begin
            n_z0 = t - HALF;
            n_x0 = -i_x;
            n_y0 = -i_y;
        end else if (t < -QTR) begin
            n_z0 = t + HALF;
            n_x0 = -i_x;
            n_y0 = -i_y;
        end
    end

    always_comb begin
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (i_vec ? (r_y[k] < 0) : (r_z[k] >= 0)) begin
                n_x[k] = r_x[k] - (r_y[k] >>> k);
                n_y[k] = r_y[k] + (r_x[k] >>> k);
                n_z[k] = r_z[k] - signed'({1'b0, ATAN_TAB[k]});
            end else begin
                n_x[k] = r_x[k] + (r_y[k] >>> k);
                n_y[k] = r_y[k] - (r_x[k] >>> k);
                n_z[k] = r_z[k] + signed'({1'b0, ATAN_TAB[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                r_x[k+1] <= n_x[k];
                r_y[k+1] <= n_y[k];
                r_z[k+1] <= n_z[k];
            end
        end
    end

    assign o_x = r_x[CORDIC_STAGES];
    assign o_y = r_y[CORDIC_STAGES];
    assign o_z = r_z[CORDIC_STAGES];

endmodule

@@ design/ecr_div.sv @@
module ecr_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [ecr_pkg::NUMW-1:0] i_num,
    input  logic [ecr_pkg::DENW-1:0]        i_den,
    output logic signed [ecr_pkg::QW-1:0]   o_quo
);
    import ecr_pkg::*;

    logic [DENW-1:0] r_rem [QB+1];
    logic [QB-1:0]   r_low [QB+1];
    logic [QB-1:0]   r_q   [QB+1];
    logic [DENW-1:0] r_den [QB+1];
    logic            r_neg [QB+1];
    logic [DENW:0]   n_sh  [QB];
    logic [DENW-1:0] n_rem [QB];
    logic [NUMW-1:0] n_abs;
    logic signed [QW-1:0] r_quo;

    assign n_abs = i_num[NUMW-1] ? NUMW'(-i_num) : NUMW'(i_num);

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            n_sh[k]  = {r_rem[k], r_low[k][QB-1]};
            n_rem[k] = (n_sh[k] >= {1'b0, r_den[k]}) ? DENW'(n_sh[k] - {1'b0, r_den[k]})
                                                    : n_sh[k][DENW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_abs[QB +: DENW];
            r_low[0] <= n_abs[QB-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_num[NUMW-1];
            for (int k = 0; k < QB; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_low[k+1] <= {r_low[k][QB-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][QB-2:0], n_sh[k] >= {1'b0, r_den[k]}};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
            r_quo <= r_neg[QB] ? -signed'({1'b0, r_q[QB]}) : signed'({1'b0, r_q[QB]});
        end
    end

    assign o_quo = r_quo;

endmodule

@@ design/elastic_collision_resolver.sv @@
// channel   valid    stall    word
// input     i_valid  o_stall  i_in   (t_in_word)
// output    o_valid  i_stall  o_out  (t_out_word)
//
// accepts one pair every cycle while the output is not stalled; the path runs through
// three cordic pipelines in series and the bit-per-stage divider.
// synchronous active-low reset clears the valid bits only.
// a stalled word at the output freezes the whole pipeline; o_stall follows it.
module elastic_collision_resolver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ecr_pkg::t_in_word i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output ecr_pkg::t_out_word o_out
);
    import ecr_pkg::*;

    logic en;
    logic [NV-1:0] r_vld;

    assign en      = !(r_vld[NV-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // stage a/b: differences and pre-scaled speeds
    t_in_word r_in;
    logic signed [16:0] r_dx, r_dy, n_dx, n_dy;
    t_sb_vec r_b, n_b;
    logic [45:0] n_pa, n_pb;

    assign n_dx = {r_in.pos_a_x[15], r_in.pos_a_x} - {r_in.pos_b_x[15], r_in.pos_b_x};
    assign n_dy = {r_in.pos_a_y[15], r_in.pos_a_y} - {r_in.pos_b_y[15], r_in.pos_b_y};
    assign n_pa = r_in.speed_a * KINV;
    assign n_pb = r_in.speed_b * KINV;

    always_comb begin
        n_b.nz  = (n_dx != 0) || (n_dy != 0);
        n_b.x0a = n_pa[45:22];
        n_b.x0b = n_pb[45:22];
        n_b.ha  = r_in.heading_a;
        n_b.hb  = r_in.heading_b;
        n_b.ma  = r_in.mass_a;
        n_b.mb  = r_in.mass_b;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in;
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_b  <= n_b;
        end
    end

    // contact angle
    logic signed [AW-1:0] v1_z;
    t_sb_vec r_d1 [LV];

    ecr_cordic u_vec_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (1'b1),
        .i_x   ({{(CW-29){r_dx[16]}}, r_dx, 12'b0}),
        .i_y   ({{(CW-29){r_dy[16]}}, r_dy, 12'b0}),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (v1_z)
    );

    // stage c: rotation angles
    logic [31:0] n_phi;
    logic [31:0] r_c_phi, r_c_tha, r_c_thb;
    logic [23:0] r_c_x0a, r_c_x0b;
    logic [15:0] r_c_ma, r_c_mb;

    assign n_phi = r_d1[LV-1].nz ? v1_z[31:0] : 32'd0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= r_b;
            for (int k = 1; k < LV; k++) r_d1[k] <= r_d1[k-1];
            r_c_phi <= n_phi;
            r_c_tha <= {r_d1[LV-1].ha, 16'b0} - n_phi;
            r_c_thb <= {r_d1[LV-1].hb, 16'b0} - n_phi;
            r_c_x0a <= r_d1[LV-1].x0a;
            r_c_x0b <= r_d1[LV-1].x0b;
            r_c_ma  <= r_d1[LV-1].ma;
            r_c_mb  <= r_d1[LV-1].mb;
        end
    end

    // into the contact frame
    logic signed [CW-1:0] ra_x, rb_x;
    logic signed [CW-1:0] ra_y, rb_y;
    t_sb_rot r_d2 [LV];

    ecr_cordic u_rot_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (1'b0),
        .i_x   ({{(CW-24){1'b0}}, r_c_x0a}),
        .i_y   ('0),
        .i_z   ({1'b0, r_c_tha}),
        .o_x   (ra_x),
        .o_y   (ra_y),
        .o_z   ()
    );

    ecr_cordic u_rot_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (1'b0),
        .i_x   ({{(CW-24){1'b0}}, r_c_x0b}),
        .i_y   ('0),
        .i_z   ({1'b0, r_c_thb}),
        .o_x   (rb_x),
        .o_y   (rb_y),
        .o_z   ()
    );

    // stages m1..m3: elastic exchange numerators
    logic signed [NW-1:0] r_m1_nax, r_m1_nay, r_m1_nbx, r_m1_nby;
    logic signed [16:0]   r_m1_diff, r_m1_ndiff, r_m1_ma, r_m1_mb;
    logic [DENW-1:0]      r_m1_sum, r_m2_sum, r_m3_sum;
    logic [31:0]          r_m1_phi, r_m2_phi, r_m3_phi;
    logic signed [NW-1:0] r_m2_nay, r_m2_nby, r_m3_nay, r_m3_nby;
    logic signed [44:0]   r_m2_p1, r_m2_p2, r_m2_p3, r_m2_p4;
    logic signed [NUMW-1:0] r_m3_na, r_m3_nb;
    logic [16:0] n_ma, n_mb;
    logic        n_both0;

    assign n_both0 = (r_d2[LV-1].ma == 16'd0) && (r_d2[LV-1].mb == 16'd0);
    assign n_ma    = n_both0 ? 17'd1 : {1'b0, r_d2[LV-1].ma};
    assign n_mb    = n_both0 ? 17'd1 : {1'b0, r_d2[LV-1].mb};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= '{phi: r_c_phi, ma: r_c_ma, mb: r_c_mb};
            for (int k = 1; k < LV; k++) r_d2[k] <= r_d2[k-1];

            r_m1_nax   <= ra_x[NW-1:0];
            r_m1_nay   <= ra_y[NW-1:0];
            r_m1_nbx   <= rb_x[NW-1:0];
            r_m1_nby   <= rb_y[NW-1:0];
            r_m1_ma    <= signed'(n_ma);
            r_m1_mb    <= signed'(n_mb);
            r_m1_diff  <= signed'(n_ma - n_mb);
            r_m1_ndiff <= signed'(n_mb - n_ma);
            r_m1_sum   <= n_ma + n_mb;
            r_m1_phi   <= r_d2[LV-1].phi;

            r_m2_p1  <= r_m1_diff * r_m1_nax;
            r_m2_p2  <= r_m1_mb * r_m1_nbx;
            r_m2_p3  <= r_m1_ndiff * r_m1_nbx;
            r_m2_p4  <= r_m1_ma * r_m1_nax;
            r_m2_nay <= r_m1_nay;
            r_m2_nby <= r_m1_nby;
            r_m2_sum <= r_m1_sum;
            r_m2_phi <= r_m1_phi;

            r_m3_na  <= NUMW'(r_m2_p1) + (NUMW'(r_m2_p2) <<< 1);
            r_m3_nb  <= NUMW'(r_m2_p3) + (NUMW'(r_m2_p4) <<< 1);
            r_m3_nay <= r_m2_nay;
            r_m3_nby <= r_m2_nby;
            r_m3_sum <= r_m2_sum;
            r_m3_phi <= r_m2_phi;
        end
    end

    // division by the mass sum
    logic signed [QW-1:0] qa, qb;
    t_sb_div r_d3 [LD];

    ecr_div u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_m3_na),
        .i_den (r_m3_sum),
        .o_quo (qa)
    );

    ecr_div u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_m3_nb),
        .i_den (r_m3_sum),
        .o_quo (qb)
    );

    // back to polar form
    logic signed [CW-1:0] va_x, vb_x;
    logic signed [AW-1:0] va_z, vb_z;
    t_sb_out r_d4 [LV];
    t_sb_out n_d4;

    always_comb begin
        n_d4.phi = r_d3[LD-1].phi;
        n_d4.za  = (qa == 0) && (r_d3[LD-1].nay == 0);
        n_d4.zb  = (qb == 0) && (r_d3[LD-1].nby == 0);
    end

    ecr_cordic u_vec_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (1'b1),
        .i_x   (CW'(qa)),
        .i_y   (CW'(r_d3[LD-1].nay)),
        .i_z   ('0),
        .o_x   (va_x),
        .o_y   (),
        .o_z   (va_z)
    );

    ecr_cordic u_vec_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vec (1'b1),
        .i_x   (CW'(qb)),
        .i_y   (CW'(r_d3[LD-1].nby)),
        .i_z   ('0),
        .o_x   (vb_x),
        .o_y   (),
        .o_z   (vb_z)
    );

    // stages p1/p2: gain removal, rounding, saturation
    logic [59:0] r_p_ma, r_p_mb;
    logic [15:0] r_p_ha, r_p_hb;
    logic        r_p_za, r_p_zb;
    logic [31:0] n_ha, n_hb;
    logic [29:0] n_mga, n_mgb;
    logic [30:0] n_ra, n_rb;
    t_out_word   r_out;

    assign n_mga = (va_x < 0) ? 30'd0 : va_x[29:0];
    assign n_mgb = (vb_x < 0) ? 30'd0 : vb_x[29:0];
    assign n_ha  = r_d4[LV-1].phi + va_z[31:0] + 32'h8000;
    assign n_hb  = r_d4[LV-1].phi + vb_z[31:0] + 32'h8000;
    assign n_ra  = ({1'b0, r_p_ma[59:30]} + 31'd128) >> 8;
    assign n_rb  = ({1'b0, r_p_mb[59:30]} + 31'd128) >> 8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[0] <= '{phi: r_m3_phi, nay: r_m3_nay, nby: r_m3_nby};
            for (int k = 1; k < LD; k++) r_d3[k] <= r_d3[k-1];
            r_d4[0] <= n_d4;
            for (int k = 1; k < LV; k++) r_d4[k] <= r_d4[k-1];

            r_p_ma <= n_mga * KINV;
            r_p_mb <= n_mgb * KINV;
            r_p_ha <= n_ha[31:16];
            r_p_hb <= n_hb[31:16];
            r_p_za <= r_d4[LV-1].za;
            r_p_zb <= r_d4[LV-1].zb;

            r_out.new_speed_a   <= r_p_za ? 16'd0 : ((n_ra > 31'd65535) ? 16'hFFFF : n_ra[15:0]);
            r_out.new_heading_a <= r_p_za ? 16'd0 : r_p_ha;
            r_out.new_speed_b   <= r_p_zb ? 16'd0 : ((n_rb > 31'd65535) ? 16'hFFFF : n_rb[15:0]);
            r_out.new_heading_b <= r_p_zb ? 16'd0 : r_p_hb;
        end
    end

    assign o_out = r_out;

endmodule

@@ tb/sv/tb_elastic_collision_resolver.sv @@
`timescale 1ns / 1ps

module tb_elastic_collision_resolver;
    import ecr_pkg::*;

    localparam int LATENCY     = 89;
    localparam int N_RANDOM    = 1230;
    localparam longint CYC_MAX = 2000000;
    localparam logic [63:0] GAIN_INV = 64'd652032874;
    localparam int NSTG = CORDIC_STAGES < 24 ? CORDIC_STAGES : 24;

    typedef struct {
        t_in_word  word;
        bit        has_fixed;
        t_out_word fixed;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_in;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_out;

    t_out_word expected_bounces[$];
    t_row      rows[$];
    int        n_errors;
    longint    cycle_count;
    bit        sink_stall_ok;

    elastic_collision_resolver u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    // drives y to zero, returns gain-scaled magnitude and angle
    task automatic vector_mode(input longint x, input longint y,
                               output longint mag, output logic [31:0] ang);
        logic [31:0] z;
        longint nx;
        longint ny;
        z = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < NSTG; i++) begin
            if (y >= 0) begin
                nx = x + fshr(y, i);
                ny = y - fshr(x, i);
                z  = z + ATAN_TAB[i];
            end else begin
                nx = x - fshr(y, i);
                ny = y + fshr(x, i);
                z  = z - ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        mag = x;
        ang = z;
    endtask

    task automatic rotate_mode(input longint x0, input logic [31:0] th,
                               output longint ox, output longint oy);
        longint t;
        longint x;
        longint y;
        longint nx;
        longint ny;
        t = longint'(th);
        y = 0;
        if (t >= 64'sh80000000) t = t - 64'sh100000000;
        if (t > 64'sh40000000) begin
            t  = t - 64'sh80000000;
            x0 = -x0;
        end else if (t < -64'sh40000000) begin
            t  = t + 64'sh80000000;
            x0 = -x0;
        end
        x = x0;
        for (int i = 0; i < NSTG; i++) begin
            if (t >= 0) begin
                nx = x - fshr(y, i);
                ny = y + fshr(x, i);
                t  = t - longint'(ATAN_TAB[i]);
            end else begin
                nx = x + fshr(y, i);
                ny = y - fshr(x, i);
                t  = t + longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        ox = x;
        oy = y;
    endtask

    task automatic to_polar(input longint vx, input longint vy, input logic [31:0] phi,
                            output logic [15:0] spd, output logic [15:0] hdg);
        longint mraw;
        logic [31:0] z;
        logic [31:0] h;
        logic [63:0] m;
        if (vx == 0 && vy == 0) begin
            spd = 16'd0;
            hdg = 16'd0;
        end else begin
            vector_mode(vx, vy, mraw, z);
            if (mraw < 0) mraw = 0;
            m   = (64'(mraw) * GAIN_INV) >> 30;
            m   = (m + 64'd128) >> 8;
            spd = (m > 64'hFFFF) ? 16'hFFFF : m[15:0];
            h   = phi + z + 32'h8000;
            hdg = h[31:16];
        end
    endtask

    task automatic predict_bounce(input t_in_word w, output t_out_word r);
        longint dx;
        longint dy;
        longint ma;
        longint mb;
        longint total;
        longint nax;
        longint nay;
        longint nbx;
        longint nby;
        longint vax;
        longint vbx;
        longint dummy;
        logic [31:0] phi;
        logic [63:0] xa;
        logic [63:0] xb;
        dx  = longint'(w.pos_a_x) - longint'(w.pos_b_x);
        dy  = longint'(w.pos_a_y) - longint'(w.pos_b_y);
        phi = 32'd0;
        if (dx != 0 || dy != 0) vector_mode(dx * 4096, dy * 4096, dummy, phi);
        xa = (64'(w.speed_a) * GAIN_INV) >> 22;
        xb = (64'(w.speed_b) * GAIN_INV) >> 22;
        rotate_mode(longint'(xa), {w.heading_a, 16'd0} - phi, nax, nay);
        rotate_mode(longint'(xb), {w.heading_b, 16'd0} - phi, nbx, nby);
        ma    = longint'(w.mass_a);
        mb    = longint'(w.mass_b);
        total = ma + mb;
        if (total == 0) begin
            ma    = 1;
            mb    = 1;
            total = 2;
        end
        vax = ((ma - mb) * nax + 2 * mb * nbx) / total;
        vbx = ((mb - ma) * nbx + 2 * ma * nax) / total;
        to_polar(vax, nay, phi, r.new_speed_a, r.new_heading_a);
        to_polar(vbx, nby, phi, r.new_speed_b, r.new_heading_b);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        n_errors++;
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    function automatic t_in_word rand_pair();
        t_in_word w;
        w = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(9))
            0: begin
                w.pos_b_x = w.pos_a_x;
                w.pos_b_y = w.pos_a_y;
            end
            1: begin
                w.pos_b_x = w.pos_a_x + 16'($signed($urandom_range(64)) - 32);
                w.pos_b_y = w.pos_a_y + 16'($signed($urandom_range(64)) - 32);
            end
            2: w.mass_b = w.mass_a;
            3: begin
                w.speed_a = $urandom_range(2);
                w.speed_b = $urandom_range(2);
            end
            4: w.heading_b = w.heading_a + 16'h8000;
            default: ;
        endcase
        if (w.mass_a == 16'd0) w.mass_a = 16'd1;
        if (w.mass_b == 16'd0) w.mass_b = 16'd1;
        return w;
    endfunction

    function automatic t_in_word mk(int ax, int ay, int bx, int by, int sa, int ha,
                                    int ma, int sb, int hb, int mb);
        t_in_word w;
        w.pos_a_x   = 16'(ax);
        w.pos_a_y   = 16'(ay);
        w.pos_b_x   = 16'(bx);
        w.pos_b_y   = 16'(by);
        w.speed_a   = 16'(sa);
        w.heading_a = 16'(ha);
        w.mass_a    = 16'(ma);
        w.speed_b   = 16'(sb);
        w.heading_b = 16'(hb);
        w.mass_b    = 16'(mb);
        return w;
    endfunction

    task automatic add_row(input t_in_word w);
        t_row r;
        r.word      = w;
        r.has_fixed = 1'b0;
        r.fixed     = '0;
        rows.push_back(r);
    endtask

    task automatic add_fixed(input t_in_word w, input t_out_word f);
        t_row r;
        r.word      = w;
        r.has_fixed = 1'b1;
        r.fixed     = f;
        rows.push_back(r);
    endtask

    task automatic send_word(input t_in_word w);
        t_out_word e;
        predict_bounce(w, e);
        expected_bounces.push_back(e);
        i_valid <= 1'b1;
        i_in    <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // directed rows: fixed results only for all-zero speeds
    task automatic build_rows();
        add_fixed(mk(0, 0, 0, 0, 0, 0, 1, 0, 0, 1), '0);
        add_fixed(mk(-32768, 32767, 32767, -32768, 0, 65535, 65535, 0, 65535, 65535), '0);
        add_row(mk(0, 0, 0, 0, 256, 0, 256, 0, 0, 256));
        add_row(mk(16, 0, 0, 0, 256, 32768, 256, 256, 0, 256));
        add_row(mk(0, 16, 0, 0, 512, 49152, 256, 0, 0, 768));
        add_row(mk(32767, 32767, -32768, -32768, 65535, 0, 65535, 65535, 32768, 65535));
        add_row(mk(-32768, -32768, 32767, 32767, 65535, 16384, 1, 65535, 49152, 65535));
        add_row(mk(-32768, 0, 32767, 0, 65535, 65535, 65535, 1, 1, 1));
        add_row(mk(0, -32768, 0, 32767, 1, 0, 1, 65535, 32768, 1));
        add_row(mk(100, 50, 100, 50, 1000, 8192, 300, 500, 40000, 900));
        add_row(mk(-5, -7, 3, 9, 300, 12345, 65535, 300, 54321, 1));
        add_row(mk(1, 0, 0, 0, 65535, 0, 256, 65535, 32768, 256));
        add_row(mk(0, 0, 1, 1, 65535, 32768, 256, 65535, 0, 256));
        add_row(mk(-1, -1, 0, 0, 12, 65535, 2, 7, 1, 3));
        add_row(mk(32767, 0, -32768, 0, 4096, 16384, 1000, 4096, 16384, 1000));
        add_row(mk(2000, -2000, -2000, 2000, 40000, 24576, 256, 40000, 57344, 512));
    endtask

    initial begin
        t_out_word got;
        t_out_word want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = o_out;
                if (expected_bounces.size() == 0) begin
                    $display("unexpected word at cycle %0d", cycle_count);
                    n_errors++;
                end else begin
                    want = expected_bounces.pop_front();
                    if (got.new_speed_a !== want.new_speed_a)
                        report_mismatch("new_speed_a", got.new_speed_a, want.new_speed_a);
                    if (got.new_heading_a !== want.new_heading_a)
                        report_mismatch("new_heading_a", got.new_heading_a,
                                        want.new_heading_a);
                    if (got.new_speed_b !== want.new_speed_b)
                        report_mismatch("new_speed_b", got.new_speed_b, want.new_speed_b);
                    if (got.new_heading_b !== want.new_heading_b)
                        report_mismatch("new_heading_b", got.new_heading_b,
                                        want.new_heading_b);
                end
            end
        end
    end

    // sink stall, bursty with quiet stretches
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_stall_ok && $urandom_range(7) == 0) begin
                n = gap_len();
                i_stall <= 1'b1;
                repeat (n > 0 ? n : 1) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(20)) @(posedge i_clk);
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYC_MAX) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        t_out_word e;
        n_errors      = 0;
        sink_stall_ok = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in          = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        build_rows();
        foreach (rows[k]) begin
            if (rows[k].has_fixed) begin
                predict_bounce(rows[k].word, e);
                if (e !== rows[k].fixed) begin
                    $display("predictor disagrees with fixed row %0d", k);
                    n_errors++;
                end
            end
            send_word(rows[k].word);
        end
        idle_for(1);
        // hold off until the pipe drains
        while (expected_bounces.size() != 0) @(posedge i_clk);
        sink_stall_ok = 1'b1;
        for (int k = 0; k < N_RANDOM; k++) begin
            send_word(rand_pair());
            if (k > 200 && k < 600 ? 1'b0 : $urandom_range(3) == 0) idle_for(gap_len());
        end
        idle_for(1);
        while (expected_bounces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/ecr_pkg.sv
design/ecr_cordic.sv
design/ecr_div.sv
design/elastic_collision_resolver.sv
tb/sv/tb_elastic_collision_resolver.sv
